// ===== hdl/romberg_reciprocal_integrator_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ROMBERG_RECIPROCAL_INTEGRATOR_MACROS_SVH
`define ROMBERG_RECIPROCAL_INTEGRATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RRI_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("rri assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RRI_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("rri assertion failed");

`endif

// ===== hdl/rri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rri_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 32;
  localparam int NPTS      = 9;
  localparam int IDX_W     = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NPTS - 1);

  localparam int DIFF_W = IN_W + 1;
  localparam int DEN_W  = 29;
  localparam int MAG_W  = DEN_W - 1;
  localparam logic signed [DEN_W-1:0] ONE8 = DEN_W'(8 << FRAC_BITS);

  // reciprocal numerator 2^(2F+3), rounding half of the divisor added on top
  localparam int ONE_POS = 2 * FRAC_BITS + 3;
  localparam int NUM_W   = (2 * FRAC_BITS + 4 > MAG_W) ? 2 * FRAC_BITS + 4 : MAG_W;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = NUM_W / DIV_BPS;

  localparam int SUM_MW  = NUM_W + 4;
  localparam int SUM_W   = SUM_MW + 1;
  localparam int LO_W    = SUM_MW / 2;
  localparam int HI_W    = SUM_MW - LO_W;
  localparam int PP_LO_W = DIFF_W + LO_W;
  localparam int PP_HI_W = DIFF_W + HI_W;
  localparam int PROD_W  = DIFF_W + SUM_MW + 1;
  localparam int SAT_EXP = 62;
  localparam int CMP_W   = (PROD_W > SAT_EXP + 1) ? PROD_W : SAT_EXP + 1;
  localparam logic [CMP_W-1:0] PROD_LIM = CMP_W'(1) << SAT_EXP;

  localparam int T_MW = SAT_EXP - FRAC_BITS - 1;
  localparam int T_W  = T_MW + 1;

  localparam int N1_W      = ((T_MW + 3 + 7) / 8) * 8;
  localparam int N1_STAGES = N1_W / 8;
  localparam int R_W       = N1_W + 1;
  localparam int N2_W      = ((T_MW + 5 + 7) / 8) * 8;
  localparam int N2_STAGES = N2_W / 8;
  localparam int E_W       = (R_W + 5 > N2_W + 1) ? R_W + 5 : N2_W + 1;

  localparam int REM_W = 4;
  localparam logic [REM_W-1:0] DIV3   = REM_W'(3);
  localparam logic [REM_W-1:0] DIV15  = REM_W'(15);
  localparam logic [REM_W-1:0] HALF3  = REM_W'(1);
  localparam logic [REM_W-1:0] HALF15 = REM_W'(7);

  localparam int SAT_W = N2_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_MAX =
    {{(SAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_MIN =
    {{(SAT_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [DEN_W-1:0]   den;
    logic signed [DIFF_W-1:0]  diff;
  } issue_t;

  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic [NUM_W-1:0]          quo;
    logic                      neg;
    logic                      zero;
    logic signed [DIFF_W-1:0]  diff;
  } sample_t;

  // level order: 0 two intervals, 1 four, 2 eight
  typedef struct packed {
    logic                     valid;
    logic                     pole;
    logic [DIFF_W-1:0]        dmag;
    logic                     dneg;
    logic [2:0][SUM_MW-1:0]   smag;
    logic [2:0]               sneg;
  } sums_t;

  typedef struct packed {
    logic                  valid;
    logic                  pole;
    logic [2:0][T_W-1:0]   t;
  } trap_t;

  // eight steps of restoring division by a small constant
  function automatic logic [REM_W+7:0] cdiv_byte(input logic [REM_W-1:0] rem,
                                                 input logic [7:0] din,
                                                 input logic [REM_W-1:0] k);
    logic [REM_W:0]   r;
    logic [REM_W-1:0] rr;
    logic [7:0]       q;
    rr = rem;
    q  = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {rr, din[i]};
      if (r >= {1'b0, k}) begin
        r    = r - {1'b0, k};
        q[i] = 1'b1;
      end
      rr = r[REM_W-1:0];
    end
    return {rr, q};
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return c[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/romberg_reciprocal_integrator.sv =====
// channel  direction  handshake               payload
// in       input      in_valid_i / in_ready_o  lower_limit_i, upper_limit_i (Q8.16)
// out      output     out_valid_o / out_ready_i trapezoid_two/four/eight_o,
//                                              romberg_estimate_o (Q16.16), pole_error_o
//
// Intake reopens when the previous transaction issues its last sample: the nine sample
// denominators enter the single pipelined reciprocal divider one per cycle while the
// output is free; stages: sequencer, divider, sum, multiply/round, constant-divide.
// Reset clears only valid bits; there is no clearing pass.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module romberg_reciprocal_integrator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [rri_pkg::IN_W-1:0]    lower_limit_i,
  input  wire logic signed [rri_pkg::IN_W-1:0]    upper_limit_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [rri_pkg::OUT_W-1:0]        trapezoid_two_o,
  output logic signed [rri_pkg::OUT_W-1:0]        trapezoid_four_o,
  output logic signed [rri_pkg::OUT_W-1:0]        trapezoid_eight_o,
  output logic signed [rri_pkg::OUT_W-1:0]        romberg_estimate_o,
  output logic                                    pole_error_o
);

  logic             en;
  logic             accept;
  rri_pkg::issue_t  issue_q, issue_d;
  rri_pkg::sample_t sample;
  rri_pkg::sums_t   sums;
  rri_pkg::trap_t   trap;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && (!issue_q.valid || issue_q.idx == rri_pkg::LAST_IDX);
  assign accept     = in_valid_i && in_ready_o;

  // walks the nine denominators 8a + 8 + i*d
  always_comb begin
    issue_d = issue_q;
    if (accept) begin
      issue_d.valid = 1'b1;
      issue_d.idx   = '0;
      issue_d.diff  = rri_pkg::DIFF_W'(upper_limit_i) - rri_pkg::DIFF_W'(lower_limit_i);
      issue_d.den   = (rri_pkg::DEN_W'(lower_limit_i) <<< 3) + rri_pkg::ONE8;
    end else if (issue_q.valid) begin
      if (issue_q.idx == rri_pkg::LAST_IDX) begin
        issue_d.valid = 1'b0;
      end else begin
        issue_d.idx = issue_q.idx + 1'b1;
        issue_d.den = issue_q.den + rri_pkg::DEN_W'(issue_q.diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q.valid <= 1'b0;
    end else if (en) begin
      issue_q <= issue_d;
    end
  end

  rri_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .issue_i  (issue_q),
    .sample_o (sample)
  );

  rri_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .sample_i (sample),
    .sums_o   (sums)
  );

  rri_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .sums_i  (sums),
    .trap_o  (trap)
  );

  rri_extrap u_extrap (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .trap_i             (trap),
    .out_valid_o        (out_valid_o),
    .trapezoid_two_o    (trapezoid_two_o),
    .trapezoid_four_o   (trapezoid_four_o),
    .trapezoid_eight_o  (trapezoid_eight_o),
    .romberg_estimate_o (romberg_estimate_o),
    .pole_error_o       (pole_error_o)
  );

endmodule

`default_nettype wire

// ===== hdl/rri_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rri_recip (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire rri_pkg::issue_t   issue_i,
  output rri_pkg::sample_t       sample_o
);

  typedef struct packed {
    logic                              valid;
    logic [rri_pkg::IDX_W-1:0]         idx;
    logic [rri_pkg::MAG_W-1:0]         rem;
    logic [rri_pkg::NUM_W-1:0]         nq;
    logic [rri_pkg::MAG_W-1:0]         m;
    logic                              neg;
    logic                              zero;
    logic signed [rri_pkg::DIFF_W-1:0] diff;
  } div_stage_t;

  div_stage_t st_q [rri_pkg::DIV_STAGES+1];
  div_stage_t st_d [rri_pkg::DIV_STAGES+1];

  // numerator bits shift out at the top while quotient bits shift in below
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t            o;
    logic [rri_pkg::MAG_W:0] r;
    o = s;
    for (int b = 0; b < rri_pkg::DIV_BPS; b++) begin
      r = {o.rem, o.nq[rri_pkg::NUM_W-1]};
      o.nq = {o.nq[rri_pkg::NUM_W-2:0], 1'b0};
      if (r >= {1'b0, o.m}) begin
        r = r - {1'b0, o.m};
        o.nq[0] = 1'b1;
      end
      o.rem = r[rri_pkg::MAG_W-1:0];
    end
    return o;
  endfunction

  logic [rri_pkg::DEN_W-1:0] den_abs;

  always_comb begin
    den_abs       = issue_i.den[rri_pkg::DEN_W-1] ? $unsigned(-issue_i.den)
                                                 : $unsigned(issue_i.den);
    st_d[0].valid = issue_i.valid;
    st_d[0].idx   = issue_i.idx;
    st_d[0].m     = den_abs[rri_pkg::MAG_W-1:0];
    st_d[0].neg   = issue_i.den[rri_pkg::DEN_W-1];
    st_d[0].zero  = (issue_i.den == '0);
    st_d[0].diff  = issue_i.diff;
    st_d[0].rem   = '0;
    st_d[0].nq    = (rri_pkg::NUM_W'(1) << rri_pkg::ONE_POS)
                  + rri_pkg::NUM_W'(den_abs[rri_pkg::MAG_W-1:1]);
    for (int k = 1; k <= rri_pkg::DIV_STAGES; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= rri_pkg::DIV_STAGES; k++) begin
        st_q[k].valid <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k <= rri_pkg::DIV_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign sample_o.valid = st_q[rri_pkg::DIV_STAGES].valid;
  assign sample_o.idx   = st_q[rri_pkg::DIV_STAGES].idx;
  assign sample_o.quo   = st_q[rri_pkg::DIV_STAGES].nq;
  assign sample_o.neg   = st_q[rri_pkg::DIV_STAGES].neg;
  assign sample_o.zero  = st_q[rri_pkg::DIV_STAGES].zero;
  assign sample_o.diff  = st_q[rri_pkg::DIV_STAGES].diff;

endmodule

`default_nettype wire

// ===== hdl/rri_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rri_accum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire rri_pkg::sample_t  sample_i,
  output rri_pkg::sums_t         sums_o
);

  logic signed [rri_pkg::SUM_W-1:0] acc_q [3];
  logic signed [rri_pkg::SUM_W-1:0] acc_d [3];
  logic                             pole_q, pole_d;
  rri_pkg::sums_t                   sums_q, sums_d;

  logic signed [rri_pkg::NUM_W:0]   s;
  logic signed [rri_pkg::SUM_W-1:0] c1;
  logic [2:0]                       w_one, w_two;
  logic [rri_pkg::SUM_W-1:0]        mag;

  always_comb begin
    s  = sample_i.zero ? '0
       : (sample_i.neg ? -$signed({1'b0, sample_i.quo}) : $signed({1'b0, sample_i.quo}));
    c1 = rri_pkg::SUM_W'(s);
    w_one = 3'b000;
    w_two = 3'b000;
    case (sample_i.idx) inside
      4'd0, 4'd8: w_one = 3'b111;   // end points weigh once at every level
      4'd4:       w_two = 3'b111;
      4'd2, 4'd6: w_two = 3'b110;
      default:    w_two = 3'b100;   // odd points only in the eight-interval sum
    endcase
    pole_d = ((sample_i.idx == '0) ? 1'b0 : pole_q) | sample_i.zero;
    for (int l = 0; l < 3; l++) begin
      acc_d[l] = ((sample_i.idx == '0) ? '0 : acc_q[l])
               + (w_one[l] ? c1 : '0) + (w_two[l] ? (c1 <<< 1) : '0);
    end
    sums_d       = sums_q;
    sums_d.valid = sample_i.valid && (sample_i.idx == rri_pkg::LAST_IDX);
    sums_d.pole  = pole_d;
    sums_d.dneg  = sample_i.diff[rri_pkg::DIFF_W-1];
    sums_d.dmag  = sample_i.diff[rri_pkg::DIFF_W-1] ? $unsigned(-sample_i.diff)
                                                  : $unsigned(sample_i.diff);
    mag = '0;
    for (int l = 0; l < 3; l++) begin
      sums_d.sneg[l] = acc_d[l][rri_pkg::SUM_W-1];
      mag = acc_d[l][rri_pkg::SUM_W-1] ? $unsigned(-acc_d[l]) : $unsigned(acc_d[l]);
      sums_d.smag[l] = mag[rri_pkg::SUM_MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q.valid <= 1'b0;
    end else if (en_i) begin
      sums_q <= sums_d;
      if (sample_i.valid) begin
        pole_q <= pole_d;
        for (int l = 0; l < 3; l++) begin
          acc_q[l] <= acc_d[l];
        end
      end
    end
  end

  assign sums_o = sums_q;

endmodule

`default_nettype wire

// ===== hdl/rri_post.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rri_post (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire rri_pkg::sums_t  sums_i,
  output rri_pkg::trap_t       trap_o
);

  typedef struct packed {
    logic                                valid;
    logic                                pole;
    logic [2:0]                          neg;
    logic [2:0][rri_pkg::PP_LO_W-1:0]    lo;
    logic [2:0][rri_pkg::PP_HI_W-1:0]    hi;
  } mul_t;

  typedef struct packed {
    logic                                valid;
    logic                                pole;
    logic [2:0]                          neg;
    logic [2:0][rri_pkg::CMP_W-1:0]      p;
  } prd_t;

  mul_t           mul_q, mul_d;
  prd_t           prd_q, prd_d;
  rri_pkg::trap_t trap_q, trap_d;

  logic [rri_pkg::CMP_W-1:0] full, rnd, shf;
  logic [rri_pkg::T_MW-1:0]  tm;

  always_comb begin
    // magnitude product split in two partial products
    mul_d.valid = sums_i.valid;
    mul_d.pole  = sums_i.pole;
    for (int l = 0; l < 3; l++) begin
      mul_d.neg[l] = sums_i.dneg ^ sums_i.sneg[l];
      mul_d.lo[l]  = rri_pkg::PP_LO_W'(sums_i.dmag)
                   * rri_pkg::PP_LO_W'(sums_i.smag[l][rri_pkg::LO_W-1:0]);
      mul_d.hi[l]  = rri_pkg::PP_HI_W'(sums_i.dmag)
                   * rri_pkg::PP_HI_W'(sums_i.smag[l][rri_pkg::SUM_MW-1:rri_pkg::LO_W]);
    end

    prd_d.valid = mul_q.valid;
    prd_d.pole  = mul_q.pole;
    prd_d.neg   = mul_q.neg;
    full = '0;
    for (int l = 0; l < 3; l++) begin
      full = (rri_pkg::CMP_W'(mul_q.hi[l]) << rri_pkg::LO_W) + rri_pkg::CMP_W'(mul_q.lo[l]);
      prd_d.p[l] = (full > rri_pkg::PROD_LIM) ? rri_pkg::PROD_LIM : full;
    end

    // scale by 2^-(F + log2(2n)), round half away from zero on the magnitude
    trap_d.valid = prd_q.valid;
    trap_d.pole  = prd_q.pole;
    rnd = '0;
    shf = '0;
    tm  = '0;
    for (int l = 0; l < 3; l++) begin
      rnd = prd_q.p[l] + (rri_pkg::CMP_W'(1) << (rri_pkg::FRAC_BITS + 1 + l));
      shf = rnd >> (rri_pkg::FRAC_BITS + 2 + l);
      tm  = shf[rri_pkg::T_MW-1:0];
      trap_d.t[l] = prd_q.neg[l] ? -{1'b0, tm} : {1'b0, tm};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q.valid  <= 1'b0;
      prd_q.valid  <= 1'b0;
      trap_q.valid <= 1'b0;
    end else if (en_i) begin
      mul_q  <= mul_d;
      prd_q  <= prd_d;
      trap_q <= trap_d;
    end
  end

  assign trap_o = trap_q;

endmodule

`default_nettype wire

// ===== hdl/rri_extrap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rri_extrap (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire rri_pkg::trap_t              trap_i,
  output logic                             out_valid_o,
  output logic signed [rri_pkg::OUT_W-1:0] trapezoid_two_o,
  output logic signed [rri_pkg::OUT_W-1:0] trapezoid_four_o,
  output logic signed [rri_pkg::OUT_W-1:0] trapezoid_eight_o,
  output logic signed [rri_pkg::OUT_W-1:0] romberg_estimate_o,
  output logic                             pole_error_o
);

  typedef struct packed {
    logic                                valid;
    logic                                pole;
    logic [2:0][rri_pkg::OUT_W-1:0]      tsat;
    logic [1:0]                          neg;
    logic [1:0][rri_pkg::REM_W-1:0]      rem;
    logic [1:0][rri_pkg::N1_W-1:0]       nq;
  } d3_t;

  typedef struct packed {
    logic                                valid;
    logic                                pole;
    logic [2:0][rri_pkg::OUT_W-1:0]      tsat;
    logic                                neg;
    logic [rri_pkg::REM_W-1:0]           rem;
    logic [rri_pkg::N2_W-1:0]            nq;
  } d15_t;

  typedef struct packed {
    logic                                valid;
    logic                                pole;
    logic [2:0][rri_pkg::OUT_W-1:0]      tsat;
    logic [rri_pkg::OUT_W-1:0]           est;
  } res_t;

  d3_t  d3_q  [rri_pkg::N1_STAGES+1];
  d3_t  d3_d  [rri_pkg::N1_STAGES+1];
  d15_t d15_q [rri_pkg::N2_STAGES+1];
  d15_t d15_d [rri_pkg::N2_STAGES+1];
  res_t res_q, res_d;

  logic signed [rri_pkg::T_W+2:0]   n1 [2];
  logic [rri_pkg::T_W+2:0]          n1m;
  logic signed [rri_pkg::R_W-1:0]   r1, r2;
  logic signed [rri_pkg::E_W-1:0]   n2;
  logic [rri_pkg::E_W-1:0]          n2m;
  logic signed [rri_pkg::N2_W:0]    est;
  logic [rri_pkg::REM_W+7:0]        stp;

  always_comb begin
    // (4*T4 - T2) and (4*T8 - T4), magnitudes with the /3 rounding offset
    d3_d[0].valid = trap_i.valid;
    d3_d[0].pole  = trap_i.pole;
    for (int l = 0; l < 3; l++) begin
      d3_d[0].tsat[l] = rri_pkg::sat_out(rri_pkg::SAT_W'($signed(trap_i.t[l])));
    end
    n1m = '0;
    for (int j = 0; j < 2; j++) begin
      n1[j] = ((rri_pkg::T_W + 3)'($signed(trap_i.t[j+1])) <<< 2)
            - (rri_pkg::T_W + 3)'($signed(trap_i.t[j]));
      n1m = n1[j][rri_pkg::T_W+2] ? $unsigned(-n1[j]) : $unsigned(n1[j]);
      d3_d[0].neg[j] = n1[j][rri_pkg::T_W+2];
      d3_d[0].rem[j] = '0;
      d3_d[0].nq[j]  = rri_pkg::N1_W'(n1m) + rri_pkg::N1_W'(rri_pkg::HALF3);
    end

    stp = '0;
    for (int k = 1; k <= rri_pkg::N1_STAGES; k++) begin
      d3_d[k] = d3_q[k-1];
      for (int j = 0; j < 2; j++) begin
        stp = rri_pkg::cdiv_byte(d3_q[k-1].rem[j], d3_q[k-1].nq[j][rri_pkg::N1_W-1 -: 8],
                                 rri_pkg::DIV3);
        d3_d[k].rem[j] = stp[rri_pkg::REM_W+7:8];
        d3_d[k].nq[j]  = {d3_q[k-1].nq[j][rri_pkg::N1_W-9:0], stp[7:0]};
      end
    end

    // 16*R2 - R1 with the /15 rounding offset
    r1 = d3_q[rri_pkg::N1_STAGES].neg[0]
       ? -$signed(rri_pkg::R_W'(d3_q[rri_pkg::N1_STAGES].nq[0]))
       :  $signed(rri_pkg::R_W'(d3_q[rri_pkg::N1_STAGES].nq[0]));
    r2 = d3_q[rri_pkg::N1_STAGES].neg[1]
       ? -$signed(rri_pkg::R_W'(d3_q[rri_pkg::N1_STAGES].nq[1]))
       :  $signed(rri_pkg::R_W'(d3_q[rri_pkg::N1_STAGES].nq[1]));
    n2  = (rri_pkg::E_W'(r2) <<< 4) - rri_pkg::E_W'(r1);
    n2m = n2[rri_pkg::E_W-1] ? $unsigned(-n2) : $unsigned(n2);
    d15_d[0].valid = d3_q[rri_pkg::N1_STAGES].valid;
    d15_d[0].pole  = d3_q[rri_pkg::N1_STAGES].pole;
    d15_d[0].tsat  = d3_q[rri_pkg::N1_STAGES].tsat;
    d15_d[0].neg   = n2[rri_pkg::E_W-1];
    d15_d[0].rem   = '0;
    d15_d[0].nq    = n2m[rri_pkg::N2_W-1:0] + rri_pkg::N2_W'(rri_pkg::HALF15);

    for (int k = 1; k <= rri_pkg::N2_STAGES; k++) begin
      d15_d[k] = d15_q[k-1];
      stp = rri_pkg::cdiv_byte(d15_q[k-1].rem, d15_q[k-1].nq[rri_pkg::N2_W-1 -: 8],
                               rri_pkg::DIV15);
      d15_d[k].rem = stp[rri_pkg::REM_W+7:8];
      d15_d[k].nq  = {d15_q[k-1].nq[rri_pkg::N2_W-9:0], stp[7:0]};
    end

    est = d15_q[rri_pkg::N2_STAGES].neg
        ? -$signed({1'b0, d15_q[rri_pkg::N2_STAGES].nq})
        :  $signed({1'b0, d15_q[rri_pkg::N2_STAGES].nq});
    res_d.valid = d15_q[rri_pkg::N2_STAGES].valid;
    res_d.pole  = d15_q[rri_pkg::N2_STAGES].pole;
    // a pole forces every estimate to zero
    res_d.tsat  = d15_q[rri_pkg::N2_STAGES].pole ? '0 : d15_q[rri_pkg::N2_STAGES].tsat;
    res_d.est   = d15_q[rri_pkg::N2_STAGES].pole ? '0 : rri_pkg::sat_out(est);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= rri_pkg::N1_STAGES; k++) begin
        d3_q[k].valid <= 1'b0;
      end
      for (int k = 0; k <= rri_pkg::N2_STAGES; k++) begin
        d15_q[k].valid <= 1'b0;
      end
      res_q.valid <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k <= rri_pkg::N1_STAGES; k++) begin
        d3_q[k] <= d3_d[k];
      end
      for (int k = 0; k <= rri_pkg::N2_STAGES; k++) begin
        d15_q[k] <= d15_d[k];
      end
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_q.valid;
  assign trapezoid_two_o    = $signed(res_q.tsat[0]);
  assign trapezoid_four_o   = $signed(res_q.tsat[1]);
  assign trapezoid_eight_o  = $signed(res_q.tsat[2]);
  assign romberg_estimate_o = $signed(res_q.est);
  assign pole_error_o       = res_q.pole;

endmodule

`default_nettype wire

// ===== hdl/rri_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "romberg_reciprocal_integrator_macros.svh"

module rri_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic signed [rri_pkg::IN_W-1:0]    lower_limit_i,
  input wire logic signed [rri_pkg::IN_W-1:0]    upper_limit_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [rri_pkg::OUT_W-1:0]   trapezoid_two_o,
  input wire logic signed [rri_pkg::OUT_W-1:0]   trapezoid_four_o,
  input wire logic signed [rri_pkg::OUT_W-1:0]   trapezoid_eight_o,
  input wire logic signed [rri_pkg::OUT_W-1:0]   romberg_estimate_o,
  input wire logic                               pole_error_o
);

  // a result stays offered until taken
  `RRI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // a pole zeroes every estimate
  `RRI_ASSERT_SAME(a_pole_zero, out_valid_o && pole_error_o, trapezoid_two_o == 0 && trapezoid_four_o == 0 && trapezoid_eight_o == 0 && romberg_estimate_o == 0)

  // a blocked output freezes intake
  `RRI_ASSERT_SAME(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)

  // samples of one transaction occupy the divider, so intake closes after an accept
  `RRI_ASSERT_NEXT(a_in_spacing, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind romberg_reciprocal_integrator rri_checker u_rri_checker (.*);

`default_nettype wire
